// File: hdl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, constants and tables for the scan sample to cartesian block.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // Default build values
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int ANGLE_BITS_DEF  = 16;

  // Configuration register indexes
  localparam logic [1:0] REG_CENTER_OFFSET   = 2'd0;
  localparam logic [1:0] REG_POINTS_PER_TURN = 2'd1;
  localparam logic [1:0] REG_PHASE_STEP      = 2'd2;

  // Configuration reset values
  localparam logic [11:0] CENTER_OFFSET_RST   = 12'd346;
  localparam logic [10:0] POINTS_PER_TURN_RST = 11'd1024;
  localparam logic [15:0] PHASE_STEP_RST      = 16'd64;

  // Field widths fixed by the interface
  localparam int OFFSET_W = 12;
  localparam int POINTS_W = 11;
  localparam int STEP_W   = 16;
  localparam int COORD_W  = 16;
  localparam int RING_W   = 16;
  localparam int INDEX_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [POINTS_W-1:0] MAX_POINTS = 11'd1024;

  // Division by 30 as multiply by reciprocal, exact for magnitudes below 2^16
  localparam int          DIV_SHIFT = 20;
  localparam logic [15:0] DIV_RECIP = 16'd34953;

  // CORDIC rotator, Q14 with gain compensation in the start vector
  localparam int TRIG_W          = 18;
  localparam int Z_W             = 18;
  localparam int CORDIC_ITERS    = 16;
  localparam int ITERS_PER_STAGE = 4;
  localparam int CORDIC_STAGES   = CORDIC_ITERS / ITERS_PER_STAGE;
  localparam int CORDIC_GAIN     = 9949;
  localparam int QUARTER_TURN    = 16384;
  localparam int HALF_TURN       = 32768;
  localparam int TRIG_FRAC       = 14;

  localparam int XY_LIMIT = 31744;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [Z_W-1:0]    zang_t;

  // atan(2^-i) in 1/65536 turn
  function automatic zang_t atan_turn(input int i);
    zang_t r;
    case (i)
      0:       r = zang_t'(8192);
      1:       r = zang_t'(4836);
      2:       r = zang_t'(2555);
      3:       r = zang_t'(1297);
      4:       r = zang_t'(651);
      5:       r = zang_t'(326);
      6:       r = zang_t'(163);
      7:       r = zang_t'(81);
      8:       r = zang_t'(41);
      9:       r = zang_t'(20);
      10:      r = zang_t'(10);
      11:      r = zang_t'(5);
      12:      r = zang_t'(3);
      13:      r = zang_t'(1);
      14:      r = zang_t'(1);
      default: r = zang_t'(0);
    endcase
    return r;
  endfunction

endpackage

// File: hdl/ssc_cordic_stage.sv
// ----------------------------------------------------------------------------
// ssc_cordic_stage
// One registered slice of the CORDIC rotator: ITERS_PER_STAGE micro-rotations, registered while en is high.
// ----------------------------------------------------------------------------
module ssc_cordic_stage #(
  parameter int FIRST_ITER = 0
) (
  input  logic          clk,
  input  logic          en,
  input  ssc_pkg::trig_t x_in,
  input  ssc_pkg::trig_t y_in,
  input  ssc_pkg::zang_t z_in,
  output ssc_pkg::trig_t x_out,
  output ssc_pkg::trig_t y_out,
  output ssc_pkg::zang_t z_out
);
  import ssc_pkg::*;

  trig_t x_next;
  trig_t y_next;
  zang_t z_next;

  // Rotate toward zero residual angle, shifts floor toward minus infinity
  always_comb begin
    trig_t xv;
    trig_t yv;
    trig_t dx;
    trig_t dy;
    zang_t zv;
    xv = x_in;
    yv = y_in;
    zv = z_in;
    for (int j = 0; j < ITERS_PER_STAGE; j++) begin
      dx = yv >>> (FIRST_ITER + j);
      dy = xv >>> (FIRST_ITER + j);
      if (zv >= 0) begin
        xv = xv - dx;
        yv = yv + dy;
        zv = zv - atan_turn(FIRST_ITER + j);
      end else begin
        xv = xv + dx;
        yv = yv - dy;
        zv = zv + atan_turn(FIRST_ITER + j);
      end
    end
    x_next = xv;
    y_next = yv;
    z_next = zv;
  end

  // Hold on stall
  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= x_next;
      y_out <= y_next;
      z_out <= z_next;
    end
  end

endmodule

// File: hdl/scan_sample_to_cartesian.sv
// ----------------------------------------------------------------------------
// scan_sample_to_cartesian
// Converts raw range samples of a rotating scan into x, y and ring height.
//
//   channel  dir  handshake          payload
//   s_*      in   tvalid/tready      tdata: sample; tuser: restart
//   m_*      out  tvalid/tready      tdata: x_pos, y_pos, height_tenths
//   cfg_*    in   cfg_valid/ready    cfg_index, cfg_data (ready out of reset)
//
// One item per cycle while the output is not stalled.
// The pipeline is the input register, the four CORDIC slices, the product
// stage and the output register; the radius stages run alongside the slices.
// A stalled output freezes the whole pipeline; s_tready follows the output
// register being free or taken in the same cycle.
// Reset clears the counters, the stage valids and restores register defaults.
// ----------------------------------------------------------------------------
module scan_sample_to_cartesian #(
  parameter int SAMPLE_BITS = ssc_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = ssc_pkg::FRAC_BITS_DEF,
  parameter int ANGLE_BITS  = ssc_pkg::ANGLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // sample
  input  logic s_tuser,                              // restart
  output logic m_tvalid,
  input  logic m_tready,
  output logic [3*ssc_pkg::COORD_W-1:0] m_tdata,     // x_pos, y_pos, height_tenths
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [ssc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ssc_pkg::*;

  localparam int MAG_W = (SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W;
  localparam int QW    = $clog2(((1 << MAG_W) - 1) / 30 + 1);
  localparam int RW    = QW + 1;
  localparam int PRODQ_W = MAG_W + 16;
  localparam int PW    = RW + TRIG_W;
  localparam int SH    = TRIG_FRAC - FRAC_BITS;

  // Configuration registers
  logic [OFFSET_W-1:0] center_offset;
  logic [POINTS_W-1:0] points_per_turn;
  logic [STEP_W-1:0]   phase_step;

  // Scan state
  logic [INDEX_W-1:0]    angle_index;
  logic [ANGLE_BITS-1:0] phase;
  logic [RING_W-1:0]     ring_index;

  logic en;
  logic take;

  assign cfg_ready = !rst;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en && !rst;
  assign take      = s_tvalid && en;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_offset   <= CENTER_OFFSET_RST;
      points_per_turn <= POINTS_PER_TURN_RST;
      phase_step      <= PHASE_STEP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_OFFSET:   center_offset   <= cfg_data[OFFSET_W-1:0];
        REG_POINTS_PER_TURN: points_per_turn <= cfg_data[POINTS_W-1:0];
        REG_PHASE_STEP:      phase_step      <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- Counter update at transfer ----
  logic [INDEX_W-1:0]    angle_used;
  logic [ANGLE_BITS-1:0] phase_used;
  logic [RING_W-1:0]     ring_used;
  logic [POINTS_W-1:0]   limit;
  logic [POINTS_W-1:0]   angle_inc;
  logic [ANGLE_BITS-1:0] step_a;
  logic [15:0]           ph16;

  assign angle_used = s_tuser ? '0 : angle_index;
  assign phase_used = s_tuser ? '0 : phase;
  assign ring_used  = s_tuser ? '0 : ring_index;
  assign angle_inc  = POINTS_W'(angle_used) + POINTS_W'(1);

  // Clamp points per turn to 1..1024
  always_comb begin
    if (points_per_turn == '0) begin
      limit = POINTS_W'(1);
    end else if (points_per_turn > MAX_POINTS) begin
      limit = MAX_POINTS;
    end else begin
      limit = points_per_turn;
    end
  end

  // Size the step to the phase accumulator and align the phase to a 16-bit turn
  if (ANGLE_BITS >= 16) begin : g_wide_angle
    assign step_a = ANGLE_BITS'(phase_step);
    assign ph16   = phase_used[ANGLE_BITS-1 -: 16];
  end else begin : g_narrow_angle
    assign step_a = phase_step[ANGLE_BITS-1:0];
    assign ph16   = {phase_used, {(16-ANGLE_BITS){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_index <= '0;
      phase       <= '0;
      ring_index  <= '0;
    end else if (take) begin
      if (angle_inc >= limit) begin
        angle_index <= '0;
        phase       <= '0;
        ring_index  <= ring_used + RING_W'(1);
      end else begin
        angle_index <= angle_inc[INDEX_W-1:0];
        phase       <= phase_used + step_a;
        ring_index  <= ring_used;
      end
    end
  end

  // ---- Stage 0: fold angle into +-quarter turn, take offset magnitude ----
  zang_t z_fold;
  logic  flip_next;
  logic signed [MAG_W:0] diff;
  logic [MAG_W-1:0] mag_next;

  always_comb begin
    z_fold    = zang_t'($signed(ph16));
    flip_next = 1'b0;
    if (z_fold > zang_t'(QUARTER_TURN)) begin
      z_fold    = z_fold - zang_t'(HALF_TURN);
      flip_next = 1'b1;
    end else if (z_fold < -zang_t'(QUARTER_TURN)) begin
      z_fold    = z_fold + zang_t'(HALF_TURN);
      flip_next = 1'b1;
    end
  end

  assign diff = $signed({1'b0, MAG_W'(s_tdata[SAMPLE_BITS-1:0])})
              - $signed({1'b0, MAG_W'(center_offset)});
  assign mag_next = diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];

  logic [7:1]          vld;
  logic [MAG_W-1:0]    mag0;
  logic                neg0;
  logic                neg1;
  logic                flip_p [0:CORDIC_STAGES];
  logic [RING_W-1:0]   ring_p [0:5];
  trig_t               x_p    [0:CORDIC_STAGES];
  trig_t               y_p    [0:CORDIC_STAGES];
  zang_t               z_p    [0:CORDIC_STAGES];
  logic [PRODQ_W-1:0]  prod1;
  logic signed [RW-1:0] rad_p [2:4];

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:1], s_tvalid};
    end
  end
  assign m_tvalid = vld[7];

  always_ff @(posedge clk) begin
    if (en) begin
      mag0      <= mag_next;
      neg0      <= diff[MAG_W];
      flip_p[0] <= flip_next;
      ring_p[0] <= ring_used;
      x_p[0]    <= trig_t'(CORDIC_GAIN);
      y_p[0]    <= '0;
      z_p[0]    <= z_fold;
    end
  end

  // ---- Stages 1..4: CORDIC slices ----
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    ssc_cordic_stage #(
      .FIRST_ITER(k * ITERS_PER_STAGE)
    ) u_stage (
      .clk   (clk),
      .en    (en),
      .x_in  (x_p[k]),
      .y_in  (y_p[k]),
      .z_in  (z_p[k]),
      .x_out (x_p[k+1]),
      .y_out (y_p[k+1]),
      .z_out (z_p[k+1])
    );

    // Carry side data alongside
    always_ff @(posedge clk) begin
      if (en) begin
        flip_p[k+1] <= flip_p[k];
        ring_p[k+1] <= ring_p[k];
      end
    end
  end

  // Radius: divide magnitude by 30, then restore sign
  always_ff @(posedge clk) begin
    if (en) begin
      prod1    <= PRODQ_W'(mag0 * DIV_RECIP);
      neg1     <= neg0;
      rad_p[2] <= neg1 ? -$signed({1'b0, prod1[DIV_SHIFT +: QW]})
                       : $signed({1'b0, prod1[DIV_SHIFT +: QW]});
      rad_p[3] <= rad_p[2];
      rad_p[4] <= rad_p[3];
    end
  end

  // ---- Stage 5: scale by cosine and sine ----
  trig_t cs;
  trig_t sn;
  logic signed [PW-1:0] px;
  logic signed [PW-1:0] py;

  assign cs = flip_p[CORDIC_STAGES] ? -x_p[CORDIC_STAGES] : x_p[CORDIC_STAGES];
  assign sn = flip_p[CORDIC_STAGES] ? -y_p[CORDIC_STAGES] : y_p[CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      px        <= PW'(rad_p[4] * cs);
      py        <= PW'(rad_p[4] * sn);
      ring_p[5] <= ring_p[CORDIC_STAGES];
    end
  end

  // ---- Stage 6: round half up, saturate, output register ----
  logic signed [PW:0] rx;
  logic signed [PW:0] ry;

  if (SH > 0) begin : g_round
    localparam logic signed [PW:0] RND = (PW+1)'(1) << (SH - 1);
    assign rx = ($signed({px[PW-1], px}) + RND) >>> SH;
    assign ry = ($signed({py[PW-1], py}) + RND) >>> SH;
  end else begin : g_no_round
    assign rx = $signed({px[PW-1], px});
    assign ry = $signed({py[PW-1], py});
  end

  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [PW:0] v);
    logic [COORD_W-1:0] r;
    if (v > $signed((PW+1)'(XY_LIMIT))) begin
      r = COORD_W'(XY_LIMIT);
    end else if (v < -$signed((PW+1)'(XY_LIMIT))) begin
      r = COORD_W'(-XY_LIMIT);
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {ring_p[5], sat_coord(ry), sat_coord(rx)};
    end
  end

endmodule

// File: verif/scan_sample_to_cartesian_tb.sv
// ----------------------------------------------------------------------------
// scan_sample_to_cartesian_tb
// Self-checking bench for the polar-to-cartesian scan converter. A tracker
// object keeps its own copy of the scan counters and registers, rotates each
// accepted sample through its own CORDIC and queues the expected x, y and
// height. Every output transfer is checked field by field against the oldest
// queued point. Stimulus covers directed corner cases, several register
// settings with random samples and backpressure.
// ----------------------------------------------------------------------------
module scan_sample_to_cartesian_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIV_CM        = 30;
  localparam int COORD_LIMIT   = 31744;
  localparam int ROT_GAIN      = 9949;
  localparam int QTURN         = 16384;
  localparam int HTURN         = 32768;
  localparam int FULL_TURN     = 65536;
  localparam int ROT_STEPS     = 16;
  localparam int COORD_SHIFT   = 6;   // Q14 trig down to 8 fractional bits
  localparam int MAX_RING_PTS  = 1024;
  localparam int LATENCY       = 6;
  localparam int LONG_HOLD     = 300;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int REPORT_MAX    = 50;

  localparam logic [1:0] REG_SPARE = 2'd3;

  // atan(2^-i) in 1/65536 turn
  localparam int ATAN_TURN [ROT_STEPS] = '{
    8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  typedef struct packed {
    logic [15:0]        height;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } coord_point_t;

  // Expected scan points and the state that produces them
  class scan_point_tracker;
    logic [11:0]  center_offset;
    logic [10:0]  points_per_turn;
    logic [15:0]  phase_step;
    logic [9:0]   angle_index;
    logic [15:0]  phase_acc;
    logic [15:0]  ring_index;
    coord_point_t pending[$];
    int           errors;

    function new();
      center_offset   = 12'd346;
      points_per_turn = 11'd1024;
      phase_step      = 16'd64;
      angle_index     = '0;
      phase_acc       = '0;
      ring_index      = '0;
      errors          = 0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [15:0] data);
      case (idx)
        ssc_pkg::REG_CENTER_OFFSET:   center_offset = data[11:0];
        ssc_pkg::REG_POINTS_PER_TURN: points_per_turn = data[10:0];
        ssc_pkg::REG_PHASE_STEP:      phase_step = data;
        default: ;
      endcase
    endfunction

    // Q14 cosine and sine of a 16-bit angle
    function void rotate(input logic [15:0] ang, output int c, output int s);
      int z, xr, yr, dx, dy;
      bit flip;
      z = (ang >= 16'd32768) ? int'(ang) - FULL_TURN : int'(ang);
      flip = 1'b0;
      xr = ROT_GAIN;
      yr = 0;
      // fold into the right half plane
      if (z > QTURN) begin
        z -= HTURN;
        flip = 1'b1;
      end else if (z < -QTURN) begin
        z += HTURN;
        flip = 1'b1;
      end
      for (int i = 0; i < ROT_STEPS; i++) begin
        dx = yr >>> i;
        dy = xr >>> i;
        if (z >= 0) begin
          xr -= dx;
          yr += dy;
          z  -= ATAN_TURN[i];
        end else begin
          xr += dx;
          yr -= dy;
          z  += ATAN_TURN[i];
        end
      end
      if (flip) begin
        xr = -xr;
        yr = -yr;
      end
      c = xr;
      s = yr;
    endfunction

    function logic [15:0] scale_coord(input int radius, input int trig);
      int v;
      v = (radius * trig + (1 << (COORD_SHIFT - 1))) >>> COORD_SHIFT;
      if (v > COORD_LIMIT) v = COORD_LIMIT;
      if (v < -COORD_LIMIT) v = -COORD_LIMIT;
      return v[15:0];
    endfunction

    // Predict the point for one accepted sample and advance the scan
    function void take_sample(input logic [15:0] tdata, input logic restart);
      int lim, radius, cs, sn;
      coord_point_t p;
      if (restart) begin
        angle_index = '0;
        phase_acc   = '0;
        ring_index  = '0;
      end
      lim = int'(points_per_turn);
      if (lim == 0) lim = 1;
      if (lim > MAX_RING_PTS) lim = MAX_RING_PTS;
      radius = (int'(tdata[11:0]) - int'(center_offset)) / DIV_CM;
      rotate(phase_acc, cs, sn);
      p.x      = scale_coord(radius, cs);
      p.y      = scale_coord(radius, sn);
      p.height = ring_index;
      pending.push_back(p);
      if (int'(angle_index) + 1 >= lim) begin
        angle_index = '0;
        phase_acc   = '0;
        ring_index  = ring_index + 16'd1;
      end else begin
        angle_index = angle_index + 10'd1;
        phase_acc   = phase_acc + phase_step;
      end
    endfunction

    function void report(input string field, input int want, input int got);
      errors++;
      if (errors <= REPORT_MAX)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_point(input logic [47:0] tdata);
      coord_point_t got, want;
      got = coord_point_t'(tdata);
      if (pending.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: unexpected result: expected none, got x %0d y %0d h %0d",
                   $time, got.x, got.y, got.height);
        return;
      end
      want = pending.pop_front();
      if (got.x != want.x) report("x_pos", want.x, got.x);
      if (got.y != want.y) report("y_pos", want.y, got.y);
      if (got.height != want.height) report("height_tenths", want.height, got.height);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // sample
  logic        s_tuser;   // restart
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // x_pos, y_pos, height_tenths
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  scan_point_tracker tracker;
  bit tx_steady;
  bit rx_steady;
  bit rx_long;
  int idle_cycles = 0;

  scan_sample_to_cartesian uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [15:0] pick_sample(input logic [11:0] offset);
    logic [15:0] d;
    d = '0;
    case ($urandom_range(15))
      0: d[11:0] = 12'h000;
      1: d[11:0] = 12'hFFF;
      2: d[11:0] = offset;
      3: d[11:0] = offset + 12'($urandom_range(60));
      4: d[11:0] = offset - 12'($urandom_range(60));
      default: d[11:0] = 12'($urandom_range(4095));
    endcase
    // junk above the sample field now and then
    if ($urandom_range(15) == 0) d[15:12] = 4'($urandom_range(15, 1));
    return d;
  endfunction

  // Input and register transfers feed the tracker; output transfers are checked
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) tracker.take_sample(s_tdata, s_tuser);
      if (m_tvalid && m_tready) tracker.check_point(m_tdata);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_MAX) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Output side: random stalls, steady stretches and one long hold-off
  initial begin : rx_side
    int rx_hold;
    rx_hold  = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else if (rx_long) begin
        rx_long = 1'b0;
        m_tready <= 1'b0;
        rx_hold = LONG_HOLD;
      end else if (rx_steady || $urandom_range(3) != 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        rx_hold = pick_gap();
      end
    end
  end

  task automatic send_sample(input logic [15:0] data, input logic restart);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= restart;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write one register; keep valid up when more writes follow
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (last) cfg_valid <= 1'b0;
  endtask

  // Stop offering samples and wait until every expected point is out
  task automatic drain_block();
    s_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  initial begin : main_seq
    logic [11:0] co;
    logic [10:0] ppt;
    logic [15:0] step;
    int          count;
    int          restart_odds;
    tracker     = new();
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    rx_long     = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: zero radius, both sample extremes, junk above the field
    send_sample(16'd346, 1'b0);
    send_sample(16'h0FFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hF123, 1'b0);
    drain_block();

    // Eight points per turn at full radius: every octant, saturated axes, then samples 29 and 30
    write_reg(ssc_pkg::REG_CENTER_OFFSET, 16'd0, 1'b0);
    write_reg(ssc_pkg::REG_POINTS_PER_TURN, 16'd8, 1'b0);
    write_reg(ssc_pkg::REG_PHASE_STEP, 16'd8192, 1'b1);
    send_sample(16'h0FFF, 1'b1);
    for (int i = 0; i < 7; i++) send_sample(16'h0FFF, 1'b0);
    send_sample(16'd29, 1'b0);
    send_sample(16'd30, 1'b0);
    drain_block();

    // Zero points per turn, negative radius and truncation toward zero
    write_reg(ssc_pkg::REG_CENTER_OFFSET, 16'd4095, 1'b0);
    write_reg(ssc_pkg::REG_POINTS_PER_TURN, 16'd0, 1'b0);
    write_reg(REG_SPARE, 16'hA5C3, 1'b0);
    write_reg(ssc_pkg::REG_PHASE_STEP, 16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'd4094, 1'b0);
    send_sample(16'd4065, 1'b0);
    send_sample(16'd4066, 1'b0);
    send_sample(16'h0FFF, 1'b1);
    drain_block();

    // Points per turn above the maximum, zero step
    write_reg(ssc_pkg::REG_CENTER_OFFSET, 16'd2048, 1'b0);
    write_reg(ssc_pkg::REG_POINTS_PER_TURN, 16'd2047, 1'b0);
    write_reg(ssc_pkg::REG_PHASE_STEP, 16'd0, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h0FFF, 1'b0);
    send_sample(16'h0800, 1'b0);
    drain_block();

    // Random samples under a series of register settings
    for (int ph = 0; ph < 7; ph++) begin
      count        = 100;
      restart_odds = 40;
      case (ph)
        0: begin
          co    = 12'd346;
          ppt   = 11'd16;
          step  = 16'd4096;
          count = 125;
        end
        1: begin
          co   = 12'($urandom_range(4095));
          ppt  = 11'($urandom_range(24, 1));
          step = 16'(FULL_TURN / int'(ppt));
        end
        2: begin
          co   = 12'd4095;
          ppt  = 11'd1024;
          step = 16'hFFFF;
        end
        3: begin
          co    = 12'd0;
          ppt   = 11'd0;
          step  = 16'($urandom_range(65535));
          count = 75;
        end
        4: begin
          // points per turn above the maximum
          co           = 12'($urandom_range(4095));
          ppt          = 11'd2047;
          step         = 16'($urandom_range(65535));
          count        = 150;
          restart_odds = 0;
        end
        5: begin
          co    = 12'($urandom_range(4095));
          ppt   = ($urandom_range(1) == 0) ? 11'($urandom_range(1024, 1))
                                           : 11'($urandom_range(8, 1));
          step  = ($urandom_range(1) == 0) ? 16'(FULL_TURN / int'(ppt))
                                           : 16'($urandom_range(65535));
        end
        default: begin
          // one ring per sample
          co           = 12'($urandom_range(4095));
          ppt          = 11'd1;
          step         = 16'($urandom_range(65535));
          count        = 80;
          restart_odds = 0;
        end
      endcase
      write_reg(ssc_pkg::REG_CENTER_OFFSET, {4'h0, co}, 1'b0);
      write_reg(ssc_pkg::REG_POINTS_PER_TURN, {5'h00, ppt}, 1'b0);
      write_reg(ssc_pkg::REG_PHASE_STEP, step, 1'b1);
      // hold the output off while the sender keeps pushing
      if (ph == 0) rx_long = 1'b1;
      tx_steady = (ph == 6);
      rx_steady = (ph == 6);
      for (int k = 0; k < count; k++) begin
        if (ph != 6 && k % 25 == 0) begin
          tx_steady = (ph == 0 && k < 50) || ($urandom_range(3) == 0);
          rx_steady = ($urandom_range(3) == 0);
        end
        send_sample(pick_sample(co),
                    (restart_odds != 0) && ($urandom_range(restart_odds - 1) == 0));
      end
      drain_block();
    end

    repeat (LATENCY * 4) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
